// ----- hdl/rrfp_pkg.sv -----
// shared constants, types and helpers of the round-robin failover picker
package rrfp_pkg;

	// number of cells in the row, set by the width of the health masks
	localparam int LANES = 16;
	// upper bound on the number of connections in a pool
	localparam int MAX_CONN = 16;
	// widths of counts and indexes
	localparam int CNT_W = 5;
	localparam int IDX_W = 4;
	// largest usable count
	localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'((MAX_CONN < LANES) ? MAX_CONN : LANES);

	// configuration register indexes
	localparam logic REG_MAIN_COUNT   = 1'b0;
	localparam logic REG_BACKUP_COUNT = 1'b1;

	// pool codes
	localparam logic POOL_MAIN   = 1'b0;
	localparam logic POOL_BACKUP = 1'b1;

	// controls sent from the sequencer to every cell
	typedef struct packed {
		logic load;
		logic shift;
	} cell_ctrl_t;

	// clamp a configured count to the usable limit
	function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] count);
		return (count > CNT_LIMIT) ? CNT_LIMIT : count;
	endfunction

endpackage

// ----- hdl/rrfp_cell.sv -----
// one cell of the search ring: holds a health bit and the scan token
module rrfp_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  rrfp_pkg::cell_ctrl_t ctrl,
	input  logic                sel,
	input  logic                last,
	input  logic                healthy_in,
	input  logic                token_in,
	output logic                token_out,
	output logic                wrap_out,
	output logic                hit
);

	logic token_q;
	logic healthy_q;

	// token register: placed on load, passed along on shift
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			token_q <= 1'b0;
		end else if (ctrl.load) begin
			token_q <= sel;
		end else if (ctrl.shift) begin
			token_q <= token_in;
		end
	end

	// health bit of this entry for the pool under search
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			healthy_q <= healthy_in;
		end
	end

	// the last cell of the ring hands its token back to the first
	assign token_out = token_q & ~last;
	assign wrap_out  = token_q & last;
	assign hit       = token_q & healthy_q;

endmodule

// ----- hdl/round_robin_failover_picker_top.sv -----
// top level of the round-robin failover picker: sequencer, cell row and output register
//
//  channel  | signals                                         | handshake
//  ---------+-------------------------------------------------+----------------------
//  config   | cfg_write, cfg_index, cfg_data                  | write on cfg_write
//  request  | in_valid, in_ready, main_healthy, backup_healthy| in_valid & in_ready
//  result   | out_valid, out_ready, granted, from_backup,     | out_valid & out_ready
//           | conn_index                                      |
//
//  one request at a time; per pool searched: a setup step, then subtractions (0 to 16) that
//  bring (pointer + 1) below the count, a step that places the token, then the token in the
//  cell row visits entries one by one (1 to count); an empty pool takes only its setup step.
//  a final step hands the result over. how long a request takes until its result is presented
//  depends on the subtractions and the token walking the cell row; the block returns to idle
//  before it takes the next request.
//  reset clears both pointers and both counts; no clearing pass is needed.
//  a finished result waits in its output register while the next request is taken;
//  the next result is held back until the previous transaction completes.
module round_robin_failover_picker_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_write,
	input  logic                         cfg_index,
	input  logic [rrfp_pkg::CNT_W-1:0]   cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [rrfp_pkg::LANES-1:0]   main_healthy,
	input  logic [rrfp_pkg::LANES-1:0]   backup_healthy,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         granted,
	output logic                         from_backup,
	output logic [rrfp_pkg::IDX_W-1:0]   conn_index
);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_SETUP = 5'b00010,
		ST_MOD   = 5'b00100,
		ST_SCAN  = 5'b01000,
		ST_FIN   = 5'b10000
	} state_t;

	state_t                       state_q;
	logic [rrfp_pkg::CNT_W-1:0]   main_count_q;
	logic [rrfp_pkg::CNT_W-1:0]   backup_count_q;
	logic [rrfp_pkg::IDX_W-1:0]   main_ptr_q;
	logic [rrfp_pkg::IDX_W-1:0]   backup_ptr_q;
	logic [rrfp_pkg::LANES-1:0]   main_mask_q;
	logic [rrfp_pkg::LANES-1:0]   backup_mask_q;
	logic                         pool_q;
	logic [rrfp_pkg::CNT_W-1:0]   n_q;
	logic [rrfp_pkg::CNT_W-1:0]   s_q;
	logic [rrfp_pkg::CNT_W-1:0]   steps_q;
	logic                         res_grant_q;
	logic                         res_backup_q;
	logic [rrfp_pkg::IDX_W-1:0]   res_idx_q;
	logic                         out_valid_q;
	logic                         granted_q;
	logic                         from_backup_q;
	logic [rrfp_pkg::IDX_W-1:0]   conn_index_q;

	logic [rrfp_pkg::CNT_W-1:0]   n_eff;
	logic [rrfp_pkg::IDX_W-1:0]   pool_ptr;
	logic [rrfp_pkg::LANES-1:0]   pool_mask;
	rrfp_pkg::cell_ctrl_t         cell_ctrl;
	logic [rrfp_pkg::LANES-1:0]   sel;
	logic [rrfp_pkg::LANES-1:0]   last;
	logic [rrfp_pkg::LANES-1:0]   token_in;
	logic [rrfp_pkg::LANES-1:0]   token_out;
	logic [rrfp_pkg::LANES-1:0]   wrap_out;
	logic [rrfp_pkg::LANES-1:0]   hit;
	logic                         hit_any;
	logic [rrfp_pkg::IDX_W-1:0]   hit_idx;
	logic                         start_ok;
	logic                         fin_go;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_count_q   <= '0;
			backup_count_q <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				rrfp_pkg::REG_MAIN_COUNT:   main_count_q   <= cfg_data;
				rrfp_pkg::REG_BACKUP_COUNT: backup_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// pool under search
	assign n_eff     = rrfp_pkg::eff_count((pool_q == rrfp_pkg::POOL_BACKUP) ?
	                                       backup_count_q : main_count_q);
	assign pool_ptr  = (pool_q == rrfp_pkg::POOL_BACKUP) ? backup_ptr_q : main_ptr_q;
	assign pool_mask = (pool_q == rrfp_pkg::POOL_BACKUP) ? backup_mask_q : main_mask_q;

	// start position is reduced below the count before the token is placed
	assign start_ok        = (s_q < n_q);
	assign cell_ctrl.load  = (state_q == ST_MOD) && start_ok;
	assign cell_ctrl.shift = (state_q == ST_SCAN);

	// per-cell position flags and ring wiring
	always_comb begin
		for (int i = 0; i < rrfp_pkg::LANES; i++) begin
			sel[i]  = (s_q == rrfp_pkg::CNT_W'(i));
			last[i] = (n_q == rrfp_pkg::CNT_W'(i + 1));
		end
		token_in[0] = |wrap_out;
		for (int i = 1; i < rrfp_pkg::LANES; i++) begin
			token_in[i] = token_out[i-1];
		end
	end

	// row of cells
	for (genvar g = 0; g < rrfp_pkg::LANES; g++) begin : g_cell
		rrfp_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (cell_ctrl),
			.sel        (sel[g]),
			.last       (last[g]),
			.healthy_in (pool_mask[g]),
			.token_in   (token_in[g]),
			.token_out  (token_out[g]),
			.wrap_out   (wrap_out[g]),
			.hit        (hit[g])
		);
	end

	// one-hot hit to index
	always_comb begin
		hit_idx = '0;
		for (int i = 0; i < rrfp_pkg::LANES; i++) begin
			if (hit[i]) begin
				hit_idx = hit_idx | rrfp_pkg::IDX_W'(i);
			end
		end
	end
	assign hit_any = |hit;

	assign fin_go   = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			main_ptr_q   <= '0;
			backup_ptr_q <= '0;
			pool_q       <= rrfp_pkg::POOL_MAIN;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						pool_q  <= rrfp_pkg::POOL_MAIN;
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					if (n_eff != '0) begin
						state_q <= ST_MOD;
					end else if (pool_q == rrfp_pkg::POOL_MAIN) begin
						pool_q <= rrfp_pkg::POOL_BACKUP;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_MOD: begin
					if (start_ok) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (hit_any) begin
						if (pool_q == rrfp_pkg::POOL_BACKUP) begin
							backup_ptr_q <= hit_idx;
						end else begin
							main_ptr_q <= hit_idx;
						end
						state_q <= ST_FIN;
					end else if (steps_q == rrfp_pkg::CNT_W'(1)) begin
						if (pool_q == rrfp_pkg::POOL_MAIN) begin
							pool_q  <= rrfp_pkg::POOL_BACKUP;
							state_q <= ST_SETUP;
						end else begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_FIN: begin
					if (fin_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// request masks, search counters and pending result
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				main_mask_q   <= main_healthy;
				backup_mask_q <= backup_healthy;
				res_grant_q   <= 1'b0;
				res_backup_q  <= 1'b0;
				res_idx_q     <= '0;
			end
			ST_SETUP: begin
				n_q <= n_eff;
				s_q <= rrfp_pkg::CNT_W'(pool_ptr) + rrfp_pkg::CNT_W'(1);
			end
			ST_MOD: begin
				if (start_ok) begin
					steps_q <= n_q;
				end else begin
					s_q <= s_q - n_q;
				end
			end
			ST_SCAN: begin
				steps_q <= steps_q - rrfp_pkg::CNT_W'(1);
				if (hit_any) begin
					res_grant_q  <= 1'b1;
					res_backup_q <= pool_q;
					res_idx_q    <= hit_idx;
				end
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_FIN) && fin_go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_FIN) && fin_go) begin
			granted_q     <= res_grant_q;
			from_backup_q <= res_backup_q;
			conn_index_q  <= res_idx_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign granted     = granted_q;
	assign from_backup = from_backup_q;
	assign conn_index  = conn_index_q;

endmodule

// ----- dv/tb_top.sv -----
// testbench for the round-robin failover picker: directed and random requests against a predictor
`timescale 1ns / 1ps

module tb_top;

	// one grant as it leaves the block
	typedef struct packed {
		logic                       granted;
		logic                       from_backup;
		logic [rrfp_pkg::IDX_W-1:0] conn_index;
	} grant_t;

	logic                         clk            = 1'b0;
	logic                         arst_n         = 1'b0;
	logic                         cfg_write      = 1'b0;
	logic                         cfg_index      = rrfp_pkg::REG_MAIN_COUNT;
	logic [rrfp_pkg::CNT_W-1:0]   cfg_data       = '0;
	logic                         in_valid       = 1'b0;
	logic                         in_ready;
	logic [rrfp_pkg::LANES-1:0]   main_healthy   = '0;
	logic [rrfp_pkg::LANES-1:0]   backup_healthy = '0;
	logic                         out_valid;
	logic                         out_ready      = 1'b0;
	logic                         granted;
	logic                         from_backup;
	logic [rrfp_pkg::IDX_W-1:0]   conn_index;

	// predictor state: counts as written, pointers as the block should hold them
	logic [rrfp_pkg::CNT_W-1:0]   main_cnt    = '0;
	logic [rrfp_pkg::CNT_W-1:0]   backup_cnt  = '0;
	logic [rrfp_pkg::IDX_W-1:0]   main_ptr    = '0;
	logic [rrfp_pkg::IDX_W-1:0]   backup_ptr  = '0;

	grant_t             grants_pending[$];
	grant_t             grant_due;
	int                 mismatch_count = 0;
	int                 burst_left     = 0;
	logic               steady_sender  = 1'b0;
	logic [31:0]        stall_cycle    = '0;
	logic [1:0]         stall_mode     = '0;

	round_robin_failover_picker_top u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.main_healthy   (main_healthy),
		.backup_healthy (backup_healthy),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.granted        (granted),
		.from_backup    (from_backup),
		.conn_index     (conn_index)
	);

	always #5 clk = ~clk;

	// run limit
	initial begin
		#(20_000_000);
		$display("== FAIL ==");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		mismatch_count++;
	endtask

	// one pass over a pool starting after the pointer; pointer moves only on a hit
	function automatic logic search_pool(input logic [rrfp_pkg::CNT_W-1:0] cnt,
			input logic [rrfp_pkg::LANES-1:0] mask, inout logic [rrfp_pkg::IDX_W-1:0] ptr,
			output logic [rrfp_pkg::IDX_W-1:0] hit);
		int n;
		int slot;
		n = (rrfp_pkg::MAX_CONN < rrfp_pkg::LANES) ? rrfp_pkg::MAX_CONN : rrfp_pkg::LANES;
		if (int'(cnt) < n)
			n = int'(cnt);
		hit = '0;
		for (int k = 1; k <= n; k++) begin
			slot = (int'(ptr) + k) % n;
			if (mask[slot]) begin
				ptr = slot[rrfp_pkg::IDX_W-1:0];
				hit = slot[rrfp_pkg::IDX_W-1:0];
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	// main pool first, backup only when main finds nothing
	function automatic grant_t predict_grant(input logic [rrfp_pkg::LANES-1:0] mh,
			input logic [rrfp_pkg::LANES-1:0] bh);
		grant_t                     g;
		logic [rrfp_pkg::IDX_W-1:0] hit;
		g = '0;
		if (search_pool(main_cnt, mh, main_ptr, hit)) begin
			g.granted     = 1'b1;
			g.from_backup = rrfp_pkg::POOL_MAIN;
			g.conn_index  = hit;
		end else if (search_pool(backup_cnt, bh, backup_ptr, hit)) begin
			g.granted     = 1'b1;
			g.from_backup = rrfp_pkg::POOL_BACKUP;
			g.conn_index  = hit;
		end
		return g;
	endfunction

	// one request transaction, then a gap when a burst ends
	task automatic send_request(input logic [rrfp_pkg::LANES-1:0] mh,
			input logic [rrfp_pkg::LANES-1:0] bh);
		int gap;
		in_valid       <= 1'b1;
		main_healthy   <= mh;
		backup_healthy <= bh;
		do @(posedge clk); while (!in_ready);
		grants_pending.insert(grants_pending.size(), predict_grant(mh, bh));
		gap = 0;
		if (!steady_sender) begin
			if (burst_left > 0) begin
				burst_left--;
			end else begin
				burst_left = $urandom_range(0, 20);
				gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 30) :
					$urandom_range(1, 4);
			end
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// hold the sender until every outstanding grant has come back
	task automatic wait_grants_returned();
		in_valid <= 1'b0;
		while (grants_pending.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// pool sizes are only changed with the block idle
	task automatic write_counts(input logic [rrfp_pkg::CNT_W-1:0] m,
			input logic [rrfp_pkg::CNT_W-1:0] b);
		wait_grants_returned();
		cfg_write <= 1'b1;
		cfg_index <= rrfp_pkg::REG_MAIN_COUNT;
		cfg_data  <= m;
		@(posedge clk);
		main_cnt   = m;
		cfg_index <= rrfp_pkg::REG_BACKUP_COUNT;
		cfg_data  <= b;
		@(posedge clk);
		backup_cnt = b;
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	// receiver back-pressure, mode picked afresh whenever the low seven bits of the cycle counter are zero
	always @(posedge clk) begin
		stall_cycle <= stall_cycle + 1;
		if (stall_cycle[6:0] == '0)
			stall_mode <= 2'($urandom_range(0, 3));
		case (stall_mode)
			2'd0: out_ready <= 1'b1;
			2'd1: out_ready <= ($urandom_range(0, 1) != 0);
			2'd2: out_ready <= (stall_cycle[2:0] == 3'd2) || (stall_cycle[2:0] == 3'd6);
			default: out_ready <= (stall_cycle[4:0] >= 5'd24);
		endcase
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (grants_pending.size() == 0) begin
				report_mismatch("grant transaction with no request outstanding");
			end else begin
				grant_due = grants_pending.pop_front();
				if (granted !== grant_due.granted)
					report_mismatch($sformatf("granted %b, wanted %b",
						granted, grant_due.granted));
				if (from_backup !== grant_due.from_backup)
					report_mismatch($sformatf("from_backup %b, wanted %b",
						from_backup, grant_due.from_backup));
				if (conn_index !== grant_due.conn_index)
					report_mismatch($sformatf("conn_index %0d, wanted %0d",
						conn_index, grant_due.conn_index));
			end
		end
	end

	function automatic logic [rrfp_pkg::LANES-1:0] random_mask();
		case ($urandom_range(0, 9))
			0, 1:    return '0;
			2:       return '1;
			3, 4:    return rrfp_pkg::LANES'(1) << $urandom_range(0, rrfp_pkg::LANES - 1);
			5:       return rrfp_pkg::LANES'($urandom) & rrfp_pkg::LANES'($urandom) &
				rrfp_pkg::LANES'($urandom);
			default: return rrfp_pkg::LANES'($urandom);
		endcase
	endfunction

	function automatic logic [rrfp_pkg::CNT_W-1:0] random_count();
		if ($urandom_range(0, 9) == 0)
			return rrfp_pkg::CNT_W'($urandom_range(17, 31));
		return rrfp_pkg::CNT_W'($urandom_range(0, 16));
	endfunction

	// both pools empty after reset: nothing is ever granted
	task automatic test_empty_pools();
		steady_sender = 1'b1;
		send_request('1, '1);
		send_request('0, '0);
	endtask

	// main pool empty, every request falls over to backup
	task automatic test_backup_only();
		write_counts(5'd0, 5'd16);
		send_request('1, 16'h0001);
		send_request('1, '1);
		send_request('1, '1);
		send_request('0, '0);
	endtask

	// full pools: rotation, top and bottom entries, failover and no grant
	task automatic test_full_pools();
		write_counts(5'd16, 5'd16);
		send_request('1, '0);
		send_request('1, '0);
		send_request('1, '0);
		send_request(16'h8000, '0);
		send_request(16'h0001, '0);
		send_request('0, '1);
		send_request('0, '0);
	endtask

	// health bits above the count must not be picked
	task automatic test_ignored_bits();
		write_counts(5'd3, 5'd2);
		send_request(16'hFFF8, 16'hFFFC);
		send_request(16'hFFF8, 16'h0002);
		send_request(16'h0004, '0);
	endtask

	// counts above the limit behave as the limit
	task automatic test_oversize_counts();
		write_counts(5'd31, 5'd17);
		send_request(16'h8000, '0);
		send_request('0, 16'h8000);
	endtask

	// pointers left beyond a count that has since been lowered
	task automatic test_pointer_past_count();
		write_counts(5'd16, 5'd16);
		send_request(16'h8000, '0);
		send_request('0, 16'h8000);
		write_counts(5'd4, 5'd1);
		send_request('1, '0);
		send_request('0, '1);
		write_counts(5'd1, 5'd0);
		send_request(16'h0001, '1);
	endtask

	// random masks over a range of pool sizes, with one pause mid-phase
	task automatic test_random_traffic();
		logic [rrfp_pkg::CNT_W-1:0] m;
		logic [rrfp_pkg::CNT_W-1:0] b;
		for (int phase = 0; phase < 12; phase++) begin
			case (phase)
				0:       begin m = 5'd16; b = 5'd16; end
				1:       begin m = 5'd1;  b = 5'd1;  end
				2:       begin m = 5'd0;  b = 5'd16; end
				3:       begin m = 5'd31; b = 5'd0;  end
				default: begin m = random_count(); b = random_count(); end
			endcase
			write_counts(m, b);
			steady_sender = (phase % 4 == 1);
			burst_left    = 0;
			for (int i = 0; i < 152; i++) begin
				if (phase == 6 && i == 76)
					wait_grants_returned();
				send_request(random_mask(), random_mask());
			end
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_pools();
		test_backup_only();
		test_full_pools();
		test_ignored_bits();
		test_oversize_counts();
		test_pointer_past_count();
		test_random_traffic();
		wait_grants_returned();
		repeat (150) @(posedge clk);
		if (grants_pending.size() != 0)
			report_mismatch("grants still outstanding at the end");
		if (mismatch_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
